// ===== sv/bra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, types and helpers for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = 16;
  localparam int WORDS     = MAP_BITS / WORD_BITS;
  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int POS_W     = $clog2(MAP_BITS);
  localparam int RUN_W     = $clog2(MAP_BITS + 1);
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_WRITE,
    ST_SCAN
  } state_t;

  // index of the highest set bit, 0 when none
  function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (w[k]) begin
        p = BIT_W'(k);
      end
    end
    return p;
  endfunction

endpackage

// ===== sv/bra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/bra_word_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_word_scan
// Evaluates one map word against the free run carried in from lower words:
// reports the lowest bit at which the run reaches the requested length and
// the run carried out of the top of the word.
// ----------------------------------------------------------------------------
module bra_word_scan (
  input  logic [bra_pkg::WORD_BITS-1:0] word,
  input  logic [bra_pkg::RUN_W-1:0]     carry,
  input  logic [bra_pkg::RUN_W-1:0]     len,
  output logic                          hit,
  output logic [bra_pkg::BIT_W-1:0]     hit_pos,
  output logic [bra_pkg::RUN_W-1:0]     carry_next
);

  import bra_pkg::*;

  logic [WORD_BITS-1:0] masked [WORD_BITS];
  logic [RUN_W-1:0]     run    [WORD_BITS];

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      masked[j] = word & WORD_BITS'((64'd1 << (j + 1)) - 64'd1);
      if (masked[j] == '0) begin
        run[j] = carry + RUN_W'(j + 1);
      end else begin
        run[j] = RUN_W'(j) - RUN_W'(msb_pos(masked[j]));
      end
      if (run[j] == len) begin
        hit     = 1'b1;
        hit_pos = BIT_W'(j);
      end
    end
    carry_next = run[WORD_BITS-1];
  end

endmodule

// ===== sv/bitmap_run_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// Usage bit map (1 used, 0 free) held in a word-wide RAM, with clear-all,
// test-bit, write-bit and first-fit free-run scan commands.
//
//   channel  | handshake           | word
//   ---------+---------------------+----------------------------------------
//   command  | start, busy         | opcode, bit_index, bit_value, run_length
//   result   | done (strobe)       | bit_is_set, found, start_index
//
// One result per command. Test and write: a RAM read, then compare or write
// back. Scan: one 16-bit RAM word per cycle, up to 64 words; rejected lengths
// answer without a scan. Clear all: a sweep that zeroes all 64 RAM words.
// After reset the same sweep runs with busy high and no result.
// The result strobe lasts one cycle and is not held.
// ----------------------------------------------------------------------------
module bitmap_run_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [bra_pkg::IDX_W-1:0]   bit_index,
  input  logic                        bit_value,
  input  logic [bra_pkg::LEN_W-1:0]   run_length,
  output logic                        done,
  output logic                        bit_is_set,
  output logic                        found,
  output logic [bra_pkg::IDX_W-1:0]   start_index
);

  import bra_pkg::*;

  state_t                state, state_next;
  logic [ADDR_W-1:0]     ptr, ptr_next;
  logic [RUN_W-1:0]      run, run_next;
  logic [RUN_W-1:0]      len, len_next;
  logic [BIT_W-1:0]      offset, offset_next;
  logic                  value, value_next;
  logic                  clr_owed, clr_owed_next;
  logic                  done_next, bit_is_set_next, found_next;
  logic [IDX_W-1:0]      start_index_next;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  logic                  hit;
  logic [BIT_W-1:0]      hit_pos;
  logic [RUN_W-1:0]      carry_next;
  logic [POS_W-1:0]      run_start;
  logic                  idx_ok, len_ok;
  logic [ADDR_W-1:0]     idx_word;

  bra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  bra_word_scan u_scan (
    .word      (ram_rdata),
    .carry     (run),
    .len       (len),
    .hit       (hit),
    .hit_pos   (hit_pos),
    .carry_next(carry_next)
  );

  assign busy      = (state != ST_IDLE);
  assign idx_ok    = int'(bit_index) < MAP_BITS;
  assign len_ok    = (run_length != '0) && (int'(run_length) <= MAP_BITS);
  assign idx_word  = ADDR_W'(bit_index >> BIT_W);
  assign run_start = POS_W'({ptr, hit_pos}) + POS_W'(1) - POS_W'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      clr_owed <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      clr_owed <= clr_owed_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    run         <= run_next;
    len         <= len_next;
    offset      <= offset_next;
    value       <= value_next;
    bit_is_set  <= bit_is_set_next;
    found       <= found_next;
    start_index <= start_index_next;
  end

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    run_next         = run;
    len_next         = len;
    offset_next      = offset;
    value_next       = value;
    clr_owed_next    = clr_owed;
    done_next        = 1'b0;
    bit_is_set_next  = 1'b0;
    found_next       = 1'b0;
    start_index_next = '0;
    ram_we           = 1'b0;
    ram_addr         = ptr;
    ram_wdata        = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ptr == ADDR_W'(WORDS - 1)) begin
          state_next    = ST_IDLE;
          done_next     = clr_owed;
          clr_owed_next = 1'b0;
          ptr_next      = '0;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          offset_next = BIT_W'(bit_index);
          value_next  = bit_value;
          unique case (op_t'(opcode))
            OP_CLEAR: begin
              ptr_next      = '0;
              clr_owed_next = 1'b1;
              state_next    = ST_CLEAR;
            end
            OP_TEST: begin
              ram_addr = idx_word;
              if (idx_ok) begin
                state_next = ST_TEST;
              end else begin
                done_next = 1'b1;
              end
            end
            OP_WRITE: begin
              ram_addr = idx_word;
              ptr_next = idx_word;
              if (idx_ok) begin
                state_next = ST_WRITE;
              end else begin
                done_next = 1'b1;
              end
            end
            OP_SCAN: begin
              ram_addr = '0;
              ptr_next = '0;
              run_next = '0;
              len_next = RUN_W'(run_length);
              if (len_ok) begin
                state_next = ST_SCAN;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_TEST: begin
        bit_is_set_next = ram_rdata[offset];
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end

      ST_WRITE: begin
        ram_wdata         = ram_rdata;
        ram_wdata[offset] = value;
        ram_we            = 1'b1;
        done_next         = 1'b1;
        state_next        = ST_IDLE;
      end

      ST_SCAN: begin
        ram_addr = ptr + ADDR_W'(1);
        run_next = carry_next;
        if (hit) begin
          found_next       = 1'b1;
          start_index_next = IDX_W'(run_start);
          done_next        = 1'b1;
          state_next       = ST_IDLE;
        end else if (ptr == ADDR_W'(WORDS - 1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/bitmap_run_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_tb
// Self-checking bench for the bitmap run allocator. A short directed list hits
// the map ends, zero and oversized run lengths and exact-fit runs. Randomised
// episodes then shape the map with batches of bit writes and probe it with
// tests and first-fit scans sized around the longest free run. Each result
// word is checked field by field against a bit-exact prediction of the map.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_tb;
  import bra_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PRINT_CAP     = 100;
  localparam int IDX_MAX       = 2 ** IDX_W - 1;
  localparam int LEN_MAX       = 2 ** LEN_W - 1;

  typedef struct {
    op_t              opcode;
    logic [IDX_W-1:0] idx;
    logic             val;
    logic [LEN_W-1:0] len;
    bit               hold;
  } cmd_t;

  typedef struct {
    logic             bit_is_set;
    logic             found;
    logic [IDX_W-1:0] start_index;
  } reply_t;

  logic             clk;
  logic             rst         = 1'b1;
  logic             start       = 1'b0;
  logic             busy;
  logic [1:0]       opcode      = '0;
  logic [IDX_W-1:0] bit_index   = '0;
  logic             bit_value   = 1'b0;
  logic [LEN_W-1:0] run_length  = '0;
  logic             done;
  logic             bit_is_set;
  logic             found;
  logic [IDX_W-1:0] start_index;

  cmd_t               queued_cmds[$];
  reply_t             pending_replies[$];
  bit [MAP_BITS-1:0]  usage_map;
  bit [MAP_BITS-1:0]  plan_map;
  bit                 hold_next  = 1'b0;
  int                 mismatches = 0;
  int                 cycles     = 0;
  int                 burst_left = 1;
  int                 gap_left   = 0;

  bitmap_run_allocator i_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .opcode,
    .bit_index,
    .bit_value,
    .run_length,
    .done,
    .bit_is_set,
    .found,
    .start_index
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int rnd_idx();
    return $urandom_range(0, IDX_MAX);
  endfunction

  function automatic int rnd_len();
    return $urandom_range(0, LEN_MAX);
  endfunction

  function automatic int rnd_bit();
    return $urandom_range(0, 1);
  endfunction

  // lowest-indexed run of len free bits
  function automatic void first_free_run(input bit [MAP_BITS-1:0] m, input int unsigned len,
                                         output bit ok, output int unsigned pos);
    int unsigned run;
    ok  = 1'b0;
    pos = 0;
    run = 0;
    if (len == 0 || len > MAP_BITS) begin
      return;
    end
    for (int unsigned i = 0; i < MAP_BITS; i++) begin
      run = m[i] ? 0 : run + 1;
      if (run == len) begin
        ok  = 1'b1;
        pos = i + 1 - len;
        return;
      end
    end
  endfunction

  function automatic int longest_free_run(input bit [MAP_BITS-1:0] m);
    int run;
    int best;
    run  = 0;
    best = 0;
    for (int i = 0; i < MAP_BITS; i++) begin
      run = m[i] ? 0 : run + 1;
      if (run > best) begin
        best = run;
      end
    end
    return best;
  endfunction

  task automatic add_cmd(input op_t op, input int idx, input int val, input int len);
    cmd_t c;
    c.opcode  = op;
    c.idx     = idx[IDX_W-1:0];
    c.val     = val[0];
    c.len     = len[LEN_W-1:0];
    c.hold    = hold_next;
    hold_next = 1'b0;
    case (op)
      OP_CLEAR: plan_map = '0;
      OP_WRITE: if (c.idx < MAP_BITS) plan_map[c.idx] = c.val;
      default: ;
    endcase
    queued_cmds.push_back(c);
  endtask

  // update the map for the accepted word and queue its result
  task automatic apply_command();
    reply_t      r;
    bit          ok;
    int unsigned pos;
    r = '{default: '0};
    case (op_t'(opcode))
      OP_CLEAR: usage_map = '0;
      OP_TEST:  if (bit_index < MAP_BITS) r.bit_is_set = usage_map[bit_index];
      OP_WRITE: if (bit_index < MAP_BITS) usage_map[bit_index] = bit_value;
      default: begin
        first_free_run(usage_map, run_length, ok, pos);
        r.found       = ok;
        r.start_index = pos[IDX_W-1:0];
      end
    endcase
    pending_replies.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
    end
    mismatches++;
  endtask

  task automatic next_burst();
    burst_left = $urandom_range(1, 24);
    case ($urandom_range(0, 4))
      0: gap_left = 0;
      1: gap_left = $urandom_range(1, 3);
      2: gap_left = $urandom_range(4, 20);
      3: gap_left = $urandom_range(0, 70);
      default: begin
        burst_left = $urandom_range(50, 200);
        gap_left   = 0;
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    logic take;
    logic send;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        apply_command();
        void'(queued_cmds.pop_front());
      end
      if (!start || take) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_cmds.size() > 0 &&
                     (!queued_cmds[0].hold || pending_replies.size() == 0)) begin
          send       = 1'b1;
          opcode     <= queued_cmds[0].opcode;
          bit_index  <= queued_cmds[0].idx;
          bit_value  <= queued_cmds[0].val;
          run_length <= queued_cmds[0].len;
          burst_left--;
          if (burst_left <= 0) begin
            next_burst();
          end
        end
        start <= send;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        report_mismatch("done unknown", '0, '0);
      end else if (done) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result word", '0, '0);
        end else begin
          want = pending_replies.pop_front();
          if (bit_is_set !== want.bit_is_set) begin
            report_mismatch("bit_is_set", IDX_W'(bit_is_set), IDX_W'(want.bit_is_set));
          end
          if (found !== want.found) begin
            report_mismatch("found", IDX_W'(found), IDX_W'(want.found));
          end
          if (start_index !== want.start_index) begin
            report_mismatch("start_index", start_index, want.start_index);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bitmap_run_allocator_tb: errors");
      $finish;
    end
  end

  initial begin
    int directed;
    int episode;
    int w;
    int base;
    int longest;
    int len;
    int pick;

    // directed corners
    add_cmd(OP_TEST, 0, rnd_bit(), rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1024);
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 0);
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1025);
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), LEN_MAX);
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1);
    add_cmd(OP_WRITE, 0, 1, rnd_len());
    add_cmd(OP_WRITE, IDX_MAX, 1, rnd_len());
    add_cmd(OP_TEST, 0, rnd_bit(), rnd_len());
    add_cmd(OP_TEST, IDX_MAX, rnd_bit(), rnd_len());
    add_cmd(OP_TEST, 512, rnd_bit(), rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1022);
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1023);
    add_cmd(OP_WRITE, 1, 1, rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1021);
    add_cmd(OP_WRITE, IDX_MAX, 0, rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1022);
    add_cmd(OP_WRITE, 1, 0, rnd_len());
    add_cmd(OP_TEST, 1, rnd_bit(), rnd_len());
    add_cmd(OP_CLEAR, rnd_idx(), rnd_bit(), rnd_len());
    add_cmd(OP_TEST, 0, rnd_bit(), rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1024);
    add_cmd(OP_WRITE, IDX_MAX, 1, rnd_len());
    add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), 1023);
    directed = queued_cmds.size();

    // random episodes: shape the map, then probe it
    episode = 0;
    while (queued_cmds.size() < directed + RANDOM_ITEMS) begin
      hold_next = (episode % 6 == 0);
      if ($urandom_range(0, 4) == 0) begin
        add_cmd(OP_CLEAR, rnd_idx(), rnd_bit(), rnd_len());
      end
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(10, 80)) begin
            add_cmd(OP_WRITE, rnd_idx(), $urandom_range(0, 3) != 0, rnd_len());
          end
        end
        1: begin
          w    = $urandom_range(16, 96);
          base = $urandom_range(0, MAP_BITS - w);
          for (int i = 0; i < w; i++) begin
            add_cmd(OP_WRITE, base + i, $urandom_range(0, 4) != 0, rnd_len());
          end
        end
        2: begin
          w    = $urandom_range(8, 64);
          base = $urandom_range(0, MAP_BITS - w);
          for (int i = 0; i < w; i++) begin
            if (plan_map[base + i] && rnd_bit()) begin
              add_cmd(OP_WRITE, base + i, 0, rnd_len());
            end
          end
          add_cmd(OP_WRITE, rnd_idx(), rnd_bit(), rnd_len());
        end
        default: begin
          repeat ($urandom_range(4, 20)) begin
            base = rnd_bit() ? 0 : MAP_BITS - 16;
            add_cmd(OP_WRITE, base + $urandom_range(0, 15), rnd_bit(), rnd_len());
          end
        end
      endcase
      repeat ($urandom_range(3, 10)) begin
        longest = longest_free_run(plan_map);
        pick    = $urandom_range(0, 9);
        if (pick < 7) begin
          case (pick)
            0: len = longest;
            1: len = longest + 1;
            2: len = (longest > 0) ? $urandom_range(1, longest) : 1;
            3: len = $urandom_range(1, 16);
            4: len = rnd_len();
            5: len = $urandom_range(1, MAP_BITS);
            default: len = (longest > 1) ? longest - 1 : 0;
          endcase
          add_cmd(OP_SCAN, rnd_idx(), rnd_bit(), len);
        end else if (pick < 9) begin
          add_cmd(OP_TEST, rnd_idx(), rnd_bit(), rnd_len());
        end else begin
          add_cmd(op_t'($urandom_range(0, 3)), rnd_idx(), rnd_bit(), rnd_len());
        end
      end
      episode++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (queued_cmds.size() > 0 || pending_replies.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bitmap_run_allocator_tb: clean");
    end else begin
      $display("bitmap_run_allocator_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bra_pkg.sv
sv/bra_ram.sv
sv/bra_word_scan.sv
sv/bitmap_run_allocator.sv
tb/bitmap_run_allocator_tb.sv
